// ----- sv/dsa_pkg.sv -----
// Shared types and constants for the decimal scale alignment block.
// No dependencies.
package dsa_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK1,
        ST_DIV1,
        ST_CHK2,
        ST_MUL,
        ST_CHK3,
        ST_DIV3,
        ST_DONE
    } state_t;

    localparam int unsigned IN_BITS = 96;
    localparam logic [31:0] RESERVED_MASK = 32'h7F00_FFFF;
    localparam int unsigned SIGN_POS = 31;

endpackage

// ----- sv/decimal_scale_align.sv -----
// Decimal operand scale alignment: nibble-serial divide and multiply by ten.
// Depends on dsa_pkg.
// Each divide or multiply step is a pass over NIB = ceil(MANTISSA_BITS/4) nibbles plus
// one check state; an item needs up to first_scale - second_scale + 2 steps.
// One item at a time: busy is high from start until done; done pulses one cycle.
// Reset (rst_n low, asynchronous) returns the controller to idle; no clearing pass.
module decimal_scale_align #(
    parameter int MANTISSA_BITS = 96,
    parameter int MAX_SCALE = 28
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [63:0] first_mant_low,
    input  logic [31:0] first_mant_high,
    input  logic [31:0] first_scale_word,
    input  logic [4:0]  first_scale,
    input  logic [63:0] second_mant_low,
    input  logic [31:0] second_mant_high,
    input  logic [31:0] second_scale_word,
    input  logic [4:0]  second_scale,
    output logic [63:0] out_first_low,
    output logic [31:0] out_first_high,
    output logic [31:0] out_first_word,
    output logic [4:0]  out_first_scale,
    output logic [63:0] out_second_low,
    output logic [31:0] out_second_high,
    output logic [4:0]  out_second_scale,
    output logic [3:0]  round_digit,
    output logic        digits_lost,
    output logic        bad_format
);

    localparam int NIB = (MANTISSA_BITS + 3) / 4;
    localparam int NW  = NIB * 4;
    localparam int CW  = $clog2(NIB);
    localparam logic [CW-1:0] LAST_CNT = CW'(NIB - 1);

    dsa_pkg::state_t state_reg, state_next;

    logic [NW-1:0] a_reg, a_next, q_reg, q_next;
    logic [NW-1:0] b_reg, b_next, p_reg, p_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]    rem_reg, rem_next;
    logic [3:0]    carry_reg, carry_next;
    logic [31:0]   word_reg, word_next;
    logic [4:0]    s1_reg, s1_next, s2_reg, s2_next;
    logic [3:0]    last_reg, last_next;
    logic          sticky_reg, sticky_next;
    logic          lost_reg, lost_next;
    logic          bad_reg, bad_next;

    logic [dsa_pkg::IN_BITS-1:0] a_in, b_in, a_out, b_out;
    logic [NW-1:0] a_ld, b_ld;
    logic [7:0]    cur;
    logic [15:0]   qprod;
    logic [3:0]    qdig, rdig;
    logic [7:0]    mprod;
    logic          last_cyc, word_ok, fits;
    logic [31:0]   word_dec;

    assign a_in = {first_mant_high, first_mant_low};
    assign b_in = {second_mant_high, second_mant_low};

    // Bits at or above MANTISSA_BITS are dropped on load.
    always_comb
    begin
        a_ld = '0;
        b_ld = '0;
        a_out = '0;
        b_out = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (i < MANTISSA_BITS && i < dsa_pkg::IN_BITS)
            begin
                a_ld[i] = a_in[i];
                b_ld[i] = b_in[i];
            end
        end
        for (int i = 0; i < dsa_pkg::IN_BITS; i++)
        begin
            if (i < NW)
            begin
                a_out[i] = a_reg[i];
                b_out[i] = b_reg[i];
            end
        end
    end

    // Divide one nibble by ten: cur < 160, so q = (cur * 205) >> 11 is exact.
    assign cur   = {rem_reg, a_reg[NW-1 -: 4]};
    assign qprod = 16'(cur) * 16'd205;
    assign qdig  = qprod[14:11];
    assign rdig  = 4'(cur - 8'(qdig) * 8'd10);

    // Multiply one nibble by ten with a carry below ten.
    assign mprod = 8'(b_reg[3:0]) * 8'd10 + 8'(carry_reg);

    assign last_cyc = (cnt_reg == LAST_CNT);
    assign word_ok  = ((word_reg & dsa_pkg::RESERVED_MASK) == 32'd0)
                   && (word_reg[23:16] <= 8'(MAX_SCALE));
    assign word_dec = {word_reg[dsa_pkg::SIGN_POS], 7'd0, word_reg[23:16] - 8'd1, 16'd0};

    // Final product nibble and carry; product must be zero above MANTISSA_BITS.
    always_comb
    begin
        logic [NW-1:0] pfull;
        pfull = {mprod[3:0], p_reg[NW-1:4]};
        fits = (mprod[7:4] == 4'd0);
        for (int i = 0; i < NW; i++)
        begin
            if (i >= MANTISSA_BITS && pfull[i])
                fits = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsa_pkg::ST_IDLE: if (start) state_next = dsa_pkg::ST_CHK1;
            dsa_pkg::ST_CHK1: state_next = (s1_reg > s2_reg) ? dsa_pkg::ST_DIV1
                                                             : dsa_pkg::ST_CHK2;
            dsa_pkg::ST_DIV1: if (last_cyc)
                state_next = (rdig == 4'd0) ? dsa_pkg::ST_CHK1 : dsa_pkg::ST_CHK2;
            dsa_pkg::ST_CHK2: state_next = (s2_reg < s1_reg) ? dsa_pkg::ST_MUL
                                                             : dsa_pkg::ST_CHK3;
            dsa_pkg::ST_MUL:  if (last_cyc)
                state_next = fits ? dsa_pkg::ST_CHK2 : dsa_pkg::ST_CHK3;
            dsa_pkg::ST_CHK3: state_next = (s1_reg > s2_reg) ? dsa_pkg::ST_DIV3
                                                             : dsa_pkg::ST_DONE;
            dsa_pkg::ST_DIV3: if (last_cyc) state_next = dsa_pkg::ST_CHK3;
            dsa_pkg::ST_DONE: state_next = dsa_pkg::ST_IDLE;
            default:          state_next = dsa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        a_next = a_reg;
        q_next = q_reg;
        b_next = b_reg;
        p_next = p_reg;
        cnt_next = '0;
        rem_next = '0;
        carry_next = '0;
        word_next = word_reg;
        s1_next = s1_reg;
        s2_next = s2_reg;
        last_next = last_reg;
        sticky_next = sticky_reg;
        lost_next = lost_reg;
        bad_next = bad_reg;
        unique case (state_reg)
            dsa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    a_next = a_ld;
                    b_next = b_ld;
                    word_next = first_scale_word;
                    s1_next = first_scale;
                    s2_next = second_scale;
                    last_next = '0;
                    sticky_next = 1'b0;
                    lost_next = 1'b0;
                    bad_next = 1'b0;
                end
            end
            dsa_pkg::ST_DIV1, dsa_pkg::ST_DIV3:
            begin
                // Rotate the dividend so it is intact after the pass; build the quotient.
                a_next = {a_reg[NW-5:0], a_reg[NW-1 -: 4]};
                q_next = {q_reg[NW-5:0], qdig};
                rem_next = rdig;
                cnt_next = cnt_reg + CW'(1);
                if (last_cyc)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == dsa_pkg::ST_DIV3 || rdig == 4'd0)
                    begin
                        s1_next = s1_reg - 5'd1;
                        if (word_ok)
                        begin
                            a_next = {q_reg[NW-5:0], qdig};
                            word_next = word_dec;
                        end
                        else
                            bad_next = 1'b1;
                        if (state_reg == dsa_pkg::ST_DIV3)
                        begin
                            last_next = word_ok ? rdig : 4'd0;
                            if (!word_ok || rdig != 4'd0)
                            begin
                                lost_next = 1'b1;
                                if (s1_reg - 5'd1 > s2_reg)
                                    sticky_next = 1'b1;
                            end
                        end
                    end
                end
            end
            dsa_pkg::ST_MUL:
            begin
                b_next = {b_reg[3:0], b_reg[NW-1:4]};
                p_next = {mprod[3:0], p_reg[NW-1:4]};
                carry_next = mprod[7:4];
                cnt_next = cnt_reg + CW'(1);
                if (last_cyc)
                begin
                    cnt_next = '0;
                    carry_next = '0;
                    if (fits)
                    begin
                        b_next = {mprod[3:0], p_reg[NW-1:4]};
                        s2_next = s2_reg + 5'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsa_pkg::ST_IDLE;
            cnt_reg <= '0;
            rem_reg <= '0;
            carry_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        q_reg <= q_next;
        b_reg <= b_next;
        p_reg <= p_next;
        word_reg <= word_next;
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        last_reg <= last_next;
        sticky_reg <= sticky_next;
        lost_reg <= lost_next;
        bad_reg <= bad_next;
    end

    always_comb
    begin
        busy = (state_reg != dsa_pkg::ST_IDLE);
        done = (state_reg == dsa_pkg::ST_DONE);
    end

    assign out_first_low    = a_out[63:0];
    assign out_first_high   = a_out[95:64];
    assign out_first_word   = word_reg;
    assign out_first_scale  = s1_reg;
    assign out_second_low   = b_out[63:0];
    assign out_second_high  = b_out[95:64];
    assign out_second_scale = s2_reg;
    assign round_digit      = (last_reg == 4'd5 && sticky_reg) ? 4'd6 : last_reg;
    assign digits_lost      = lost_reg;
    assign bad_format       = bad_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer accepted but block not busy");

    a_done_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> s1_reg <= s2_reg)
        else $error("result issued with scales not aligned");

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done held longer than one cycle");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_CNT)
        else $error("nibble counter out of range");

endmodule
